// File: design/prq_pkg.sv
`timescale 1ns / 1ps
// prq_pkg: field widths, codes and record types for the packet ring queue.
// No dependencies; used by prq_outreg, packet_ring_queue and both bench files.
package prq_pkg;

	localparam int BYTE_W   = 8;
	localparam int LEN_W    = 11;
	localparam int ID_W     = 16;
	localparam int BUDGET_W = 14;
	localparam int STAT_W   = 3;

	localparam logic [BUDGET_W-1:0] BUDGET_RESET = 14'd8192;
	localparam logic [LEN_W-1:0]    LIMIT_RESET  = 11'd1024;

	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POP  = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		ST_TAKEN  = 3'd0,
		ST_COMMIT = 3'd1,
		ST_REJECT = 3'd2,
		ST_POP    = 3'd3,
		ST_EMPTY  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		MD_IDLE    = 2'd0,
		MD_ACCEPT  = 2'd1,
		MD_DISCARD = 2'd2
	} mode_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} fsm_t;

	typedef enum logic [0:0] {
		CFG_BUDGET = 1'b0,
		CFG_LIMIT  = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic              action;
		logic [BYTE_W-1:0] data_byte;
		logic              last;
		logic [LEN_W-1:0]  packet_length;
		logic [ID_W-1:0]   packet_id;
	} item_t;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [ID_W-1:0]  id;
	} meta_t;

	typedef struct packed {
		status_t           status;
		logic [BYTE_W-1:0] out_byte;
		logic [ID_W-1:0]   out_id;
		logic [LEN_W-1:0]  out_length;
		logic              out_last;
	} result_t;

endpackage

// File: design/prq_ram.sv
`timescale 1ns / 1ps
// prq_ram: generic single-clock RAM, one write and one read port, registered read.
// No dependencies.
module prq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: design/prq_outreg.sv
`timescale 1ns / 1ps
// prq_outreg: result register on the output channel; holds a beat until taken.
// Depends on prq_pkg.
module prq_outreg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  prq_pkg::result_t res_in,
	output logic             ld_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output prq_pkg::result_t res_out
);

	logic             valid_q;
	prq_pkg::result_t res_q;

	assign ld_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign res_out   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

// File: design/packet_ring_queue.sv
`timescale 1ns / 1ps
// packet_ring_queue: top level, slot ring control, admission check and pop path.
// Depends on prq_pkg, prq_ram and prq_outreg.
//
// Usage:
//  Input channel (in_valid/in_ready) carries one push or pop beat; each beat gives
//  exactly one result beat on the output channel (out_valid/out_ready).
//  Pushes stream a packet byte by byte; the first byte is checked against the size
//  limit, the free slot count and the byte budget, and a rejected packet is dropped
//  through its last byte. Pops return the head packet byte by byte, cut to read_limit.
//  Configuration: cfg_valid/cfg_ready with cfg_index (0 byte budget, 1 read limit)
//  and cfg_data; cfg_ready is always high. Write only while the block is idle.
//  Timing: the accept cycle registers the beat and issues the reads of the byte
//  memory and the slot record memory; the execute state then uses the read data,
//  writes back and loads the output register. A new item is accepted only once the
//  last has left execute, as the execute state needs the registered memory reads.
//  Reset: queue empty, budget 8192, read limit 1024. Memories are not cleared and
//  need no clearing pass; only written entries are ever used.
//  Receiver stall: the output register holds its beat; one further item may be
//  accepted and waits in execute until the register frees.
module packet_ring_queue #(
	parameter int MAX_BYTES_PER_PACKET = 1024,
	parameter int SLOT_COUNT           = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [7:0]  data_byte,
	input  logic        last,
	input  logic [10:0] packet_length,
	input  logic [15:0] packet_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [7:0]  out_byte,
	output logic [15:0] out_id,
	output logic [10:0] out_length,
	output logic        out_last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [13:0] cfg_data
);

	localparam int LW     = prq_pkg::LEN_W;
	localparam int SW     = $clog2(SLOT_COUNT);
	localparam int CW     = $clog2(SLOT_COUNT + 1);
	localparam int DEPTH  = SLOT_COUNT * MAX_BYTES_PER_PACKET;
	localparam int AW     = $clog2(DEPTH);
	localparam int MW     = $clog2(MAX_BYTES_PER_PACKET + 1);
	localparam int XW     = (MW > LW) ? MW : LW;
	localparam int NW_RAW = $clog2(DEPTH + (1 << LW) + 1);
	localparam int NW     = (NW_RAW > prq_pkg::BUDGET_W) ? NW_RAW : prq_pkg::BUDGET_W;
	localparam int MTW    = prq_pkg::LEN_W + prq_pkg::ID_W;

	prq_pkg::fsm_t    state_q, state_d;
	prq_pkg::item_t   item_q;
	prq_pkg::mode_t   mode_q, mode_d;
	logic [SW-1:0]    head_q, head_d, tail_q, tail_d;
	logic [CW-1:0]    count_q, count_d;
	logic [LW-1:0]    wo_q, wo_d, ro_q, ro_d;
	logic [prq_pkg::ID_W-1:0]     id_q, id_d;
	logic [prq_pkg::BUDGET_W-1:0] budget_q;
	logic [LW-1:0]    limit_q;

	logic             accept, exec_fire, ld_ready;
	prq_pkg::result_t res_d, res_o;

	logic             byte_we;
	logic [AW-1:0]    byte_waddr, byte_raddr;
	logic [7:0]       byte_rd;
	logic             meta_we;
	prq_pkg::meta_t   meta_wd, meta_rd;
	logic [MTW-1:0]   meta_rd_raw;

	logic [SW-1:0]    head_nx, tail_nx;
	logic [NW-1:0]    need;
	logic             fail;
	prq_pkg::mode_t   mode_eff;
	logic [LW-1:0]    ew, ew_n, deliver;
	logic             wr_ok, fin;
	logic [prq_pkg::ID_W-1:0] id_eff;

	assign accept    = in_valid && in_ready;
	assign exec_fire = (state_q == prq_pkg::S_EXEC) && ld_ready;
	assign cfg_ready = 1'b1;

	assign head_nx = (head_q == SW'(SLOT_COUNT - 1)) ? '0 : head_q + SW'(1);
	assign tail_nx = (tail_q == SW'(SLOT_COUNT - 1)) ? '0 : tail_q + SW'(1);

	assign byte_raddr = AW'(NW'(head_q) * NW'(MAX_BYTES_PER_PACKET) + NW'(ro_q));
	assign byte_waddr = AW'(NW'(tail_q) * NW'(MAX_BYTES_PER_PACKET) + NW'(ew));
	assign meta_rd    = prq_pkg::meta_t'(meta_rd_raw);

	prq_ram #(.WIDTH(prq_pkg::BYTE_W), .DEPTH(DEPTH)) u_byte_ram (
		.clk     (clk),
		.wr_en   (byte_we && exec_fire),
		.wr_addr (byte_waddr),
		.wr_data (item_q.data_byte),
		.rd_en   (accept),
		.rd_addr (byte_raddr),
		.rd_data (byte_rd)
	);

	prq_ram #(.WIDTH(MTW), .DEPTH(SLOT_COUNT)) u_meta_ram (
		.clk     (clk),
		.wr_en   (meta_we && exec_fire),
		.wr_addr (tail_q),
		.wr_data (meta_wd),
		.rd_en   (accept),
		.rd_addr (head_q),
		.rd_data (meta_rd_raw)
	);

	prq_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (exec_fire),
		.res_in    (res_d),
		.ld_ready  (ld_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_out   (res_o)
	);

	assign status     = res_o.status;
	assign out_byte   = res_o.out_byte;
	assign out_id     = res_o.out_id;
	assign out_length = res_o.out_length;
	assign out_last   = res_o.out_last;

	// admission check on the first byte of a packet
	assign need = NW'(count_q) * NW'(MAX_BYTES_PER_PACKET) + NW'(item_q.packet_length);
	assign fail = (XW'(item_q.packet_length) > XW'(MAX_BYTES_PER_PACKET))
		|| (count_q >= CW'(SLOT_COUNT))
		|| (need > NW'(budget_q));

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			prq_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = prq_pkg::S_EXEC;
				end
			end
			prq_pkg::S_EXEC: begin
				if (ld_ready) begin
					state_d = prq_pkg::S_IDLE;
				end
			end
			default: state_d = prq_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		count_d  = count_q;
		wo_d     = wo_q;
		ro_d     = ro_q;
		mode_d   = mode_q;
		id_d     = id_q;
		res_d    = '0;
		byte_we  = 1'b0;
		meta_we  = 1'b0;
		mode_eff = mode_q;
		ew       = wo_q;
		ew_n     = wo_q;
		id_eff   = id_q;
		wr_ok    = 1'b0;
		deliver  = (meta_rd.len < limit_q) ? meta_rd.len : limit_q;
		fin      = ({1'b0, ro_q} + (LW + 1)'(1)) >= {1'b0, deliver};
		meta_wd  = '0;
		if (item_q.action == prq_pkg::ACT_POP) begin
			if (count_q == '0) begin
				res_d.status = prq_pkg::ST_EMPTY;
			end else begin
				res_d.status     = prq_pkg::ST_POP;
				res_d.out_byte   = (ro_q < deliver) ? byte_rd : '0;
				res_d.out_id     = meta_rd.id;
				res_d.out_length = deliver;
				res_d.out_last   = fin;
				if (fin) begin
					ro_d    = '0;
					head_d  = head_nx;
					count_d = count_q - CW'(1);
				end else begin
					ro_d = ro_q + LW'(1);
				end
			end
		end else begin
			if (mode_q == prq_pkg::MD_IDLE) begin
				if (fail) begin
					mode_eff = prq_pkg::MD_DISCARD;
				end else begin
					mode_eff = prq_pkg::MD_ACCEPT;
					ew       = '0;
					id_eff   = item_q.packet_id;
				end
			end
			id_d = id_eff;
			if (mode_eff == prq_pkg::MD_DISCARD) begin
				res_d.status = prq_pkg::ST_REJECT;
				mode_d = item_q.last ? prq_pkg::MD_IDLE : prq_pkg::MD_DISCARD;
			end else begin
				wr_ok   = (ew < item_q.packet_length)
					&& (XW'(ew) < XW'(MAX_BYTES_PER_PACKET));
				byte_we = wr_ok;
				ew_n    = ew + LW'(wr_ok);
				if (item_q.last) begin
					meta_we      = 1'b1;
					meta_wd.len  = ew_n;
					meta_wd.id   = id_eff;
					tail_d       = tail_nx;
					count_d      = count_q + CW'(1);
					wo_d         = '0;
					mode_d       = prq_pkg::MD_IDLE;
					res_d.status = prq_pkg::ST_COMMIT;
				end else begin
					wo_d         = ew_n;
					mode_d       = prq_pkg::MD_ACCEPT;
					res_d.status = prq_pkg::ST_TAKEN;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			wo_q    <= '0;
			ro_q    <= '0;
			mode_q  <= prq_pkg::MD_IDLE;
		end else if (exec_fire) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			wo_q    <= wo_d;
			ro_q    <= ro_d;
			mode_q  <= mode_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= prq_pkg::BUDGET_RESET;
			limit_q  <= prq_pkg::LIMIT_RESET;
		end else if (cfg_valid) begin
			unique case (prq_pkg::cfg_idx_t'(cfg_index))
				prq_pkg::CFG_BUDGET: budget_q <= cfg_data;
				prq_pkg::CFG_LIMIT:  limit_q  <= cfg_data[LW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.action        <= action;
			item_q.data_byte     <= data_byte;
			item_q.last          <= last;
			item_q.packet_length <= packet_length;
			item_q.packet_id     <= packet_id;
		end
		if (exec_fire) begin
			id_q <= id_d;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(SLOT_COUNT))
		else $error("slot count over ring size");

	a_free_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		exec_fire && res_d.status == prq_pkg::ST_POP && res_d.out_last
		|=> count_q == $past(count_q) - CW'(1))
		else $error("final pop beat did not free a slot");

	a_commit_fills: assert property (@(posedge clk) disable iff (!arst_n)
		exec_fire && res_d.status == prq_pkg::ST_COMMIT
		|=> count_q == $past(count_q) + CW'(1))
		else $error("commit did not take a slot");

	a_hold_exec: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == prq_pkg::S_EXEC && !ld_ready |=> state_q == prq_pkg::S_EXEC)
		else $error("execute left while output register full");

	a_empty_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == prq_pkg::ST_EMPTY
		|-> out_byte == '0 && out_id == '0 && out_length == '0 && !out_last)
		else $error("empty beat carries payload");

endmodule

// File: bench/prq_answer_check.sv
`timescale 1ns / 1ps
// prq_answer_check: watches the item, result and register channels of packet_ring_queue,
// predicts every result beat from its own copy of the queue and compares field by field.
// Depends on prq_pkg.
module prq_answer_check #(
	parameter int MAX_BYTES = 1024,
	parameter int SLOTS     = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic                        action,
	input  logic [prq_pkg::BYTE_W-1:0]  data_byte,
	input  logic                        last,
	input  logic [prq_pkg::LEN_W-1:0]   packet_length,
	input  logic [prq_pkg::ID_W-1:0]    packet_id,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [prq_pkg::STAT_W-1:0]  status,
	input  logic [prq_pkg::BYTE_W-1:0]  out_byte,
	input  logic [prq_pkg::ID_W-1:0]    out_id,
	input  logic [prq_pkg::LEN_W-1:0]   out_length,
	input  logic                        out_last,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  prq_pkg::cfg_idx_t           cfg_index,
	input  logic [prq_pkg::BUDGET_W-1:0] cfg_data,
	output int                          mismatch_count,
	output int                          answers_due
);

	localparam int LW  = prq_pkg::LEN_W;
	localparam int SAW = $clog2(SLOTS);
	localparam int PAW = $clog2(SLOTS * MAX_BYTES);

	logic [prq_pkg::BYTE_W-1:0]   pkt_bytes [SLOTS*MAX_BYTES];
	logic [prq_pkg::LEN_W-1:0]    slot_len [SLOTS];
	logic [prq_pkg::ID_W-1:0]     slot_tag [SLOTS];
	int                           rd_head, wr_tail, slots_used, fill_pos, drain_pos;
	prq_pkg::mode_t               fill_mode;
	logic [prq_pkg::BUDGET_W-1:0] byte_budget;
	logic [prq_pkg::LEN_W-1:0]    read_cap;
	prq_pkg::result_t             pending_answers [$];

	always @(posedge clk or negedge arst_n) begin
		prq_pkg::result_t want;
		int               deliver;
		if (!arst_n) begin
			rd_head = 0;
			wr_tail = 0;
			slots_used = 0;
			fill_pos = 0;
			drain_pos = 0;
			fill_mode = prq_pkg::MD_IDLE;
			byte_budget = prq_pkg::BUDGET_RESET;
			read_cap = prq_pkg::LIMIT_RESET;
			pending_answers.delete();
			mismatch_count = 0;
			answers_due <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == prq_pkg::CFG_BUDGET)
					byte_budget = cfg_data;
				else
					read_cap = cfg_data[LW-1:0];
			end
			if (in_valid && in_ready) begin
				want = '0;
				if (action == prq_pkg::ACT_PUSH) begin
					// admission is decided on the first beat of a packet only
					if (fill_mode == prq_pkg::MD_IDLE) begin
						if (int'(packet_length) > MAX_BYTES || slots_used >= SLOTS ||
								slots_used * MAX_BYTES + int'(packet_length) > int'(byte_budget))
							fill_mode = prq_pkg::MD_DISCARD;
						else begin
							fill_mode = prq_pkg::MD_ACCEPT;
							fill_pos = 0;
							slot_tag[SAW'(wr_tail)] = packet_id;
						end
					end
					if (fill_mode == prq_pkg::MD_DISCARD) begin
						want.status = prq_pkg::ST_REJECT;
						if (last)
							fill_mode = prq_pkg::MD_IDLE;
					end else begin
						if (fill_pos < int'(packet_length) && fill_pos < MAX_BYTES) begin
							pkt_bytes[PAW'(wr_tail*MAX_BYTES + fill_pos)] = data_byte;
							fill_pos++;
						end
						want.status = prq_pkg::ST_TAKEN;
						if (last) begin
							slot_len[SAW'(wr_tail)] = LW'(fill_pos);
							wr_tail = (wr_tail + 1) % SLOTS;
							slots_used++;
							fill_pos = 0;
							fill_mode = prq_pkg::MD_IDLE;
							want.status = prq_pkg::ST_COMMIT;
						end
					end
				end else if (slots_used == 0) begin
					want.status = prq_pkg::ST_EMPTY;
				end else begin
					deliver = (slot_len[SAW'(rd_head)] < read_cap) ?
						int'(slot_len[SAW'(rd_head)]) : int'(read_cap);
					want.status = prq_pkg::ST_POP;
					if (drain_pos < deliver)
						want.out_byte = pkt_bytes[PAW'(rd_head*MAX_BYTES + drain_pos)];
					want.out_id = slot_tag[SAW'(rd_head)];
					want.out_length = LW'(deliver);
					want.out_last = (drain_pos + 1 >= deliver);
					if (want.out_last) begin
						drain_pos = 0;
						rd_head = (rd_head + 1) % SLOTS;
						slots_used--;
					end else
						drain_pos++;
				end
				pending_answers.push_back(want);
			end
			if (out_valid && out_ready) begin
				if (pending_answers.size() == 0) begin
					$error("result beat with none outstanding: status %0d", status);
					mismatch_count++;
				end else begin
					want = pending_answers.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						mismatch_count++;
					end
					if (out_byte !== want.out_byte) begin
						$error("out_byte: expected %0d, got %0d", want.out_byte, out_byte);
						mismatch_count++;
					end
					if (out_id !== want.out_id) begin
						$error("out_id: expected %0d, got %0d", want.out_id, out_id);
						mismatch_count++;
					end
					if (out_length !== want.out_length) begin
						$error("out_length: expected %0d, got %0d", want.out_length, out_length);
						mismatch_count++;
					end
					if (out_last !== want.out_last) begin
						$error("out_last: expected %0d, got %0d", want.out_last, out_last);
						mismatch_count++;
					end
				end
			end
			answers_due <= pending_answers.size();
		end
	end

endmodule

// File: bench/packet_ring_queue_tb.sv
`timescale 1ns / 1ps
// packet_ring_queue_tb: drives push and pop beats and register writes into packet_ring_queue
// under random back-pressure; prq_answer_check does the prediction. Depends on prq_pkg.
module packet_ring_queue_tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int BW          = prq_pkg::BYTE_W;
	localparam int LW          = prq_pkg::LEN_W;
	localparam int IW          = prq_pkg::ID_W;
	localparam int GW          = prq_pkg::BUDGET_W;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic                action;
	logic [BW-1:0]       data_byte;
	logic                last;
	logic [LW-1:0]       packet_length;
	logic [IW-1:0]       packet_id;
	logic                out_valid;
	logic                out_ready;
	logic [prq_pkg::STAT_W-1:0] status;
	logic [BW-1:0]       out_byte;
	logic [IW-1:0]       out_id;
	logic [LW-1:0]       out_length;
	logic                out_last;
	logic                cfg_valid;
	logic                cfg_ready;
	prq_pkg::cfg_idx_t   cfg_index;
	logic [GW-1:0]       cfg_data;
	int                  mismatch_count;
	int                  answers_due;

	int                  gap_pct;
	logic                hold_req;
	int                  beats_sent;
	int                  settings_used;
	int                  cycle_count;

	packet_ring_queue DUT (.*);
	prq_answer_check answer_check (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		logic hold_seen;
		int   hold_left;
		hold_seen = 1'b0;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else
				out_ready <= ($urandom_range(99) >= gap_pct);
		end
	end

	task automatic drive_beat(input logic act, input logic [BW-1:0] b, input logic lst,
			input logic [LW-1:0] len, input logic [IW-1:0] id);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		data_byte <= b;
		last <= lst;
		packet_length <= len;
		packet_id <= id;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		beats_sent++;
	endtask

	task automatic pop_beat();
		drive_beat(prq_pkg::ACT_POP, BW'($urandom_range(255)), 1'($urandom_range(1)),
			LW'($urandom_range(2047)), IW'($urandom_range(65535)));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (answers_due != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input prq_pkg::cfg_idx_t idx, input logic [GW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic apply_settings(input logic [GW-1:0] budget, input logic [LW-1:0] cap);
		wait_drained();
		write_reg(prq_pkg::CFG_BUDGET, budget);
		write_reg(prq_pkg::CFG_LIMIT, GW'(cap));
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// mostly well-formed packets with random length and content, pops mixed in,
	// plus a share of fully random beats
	task automatic run_traffic(input int n_items, input int pop_pct, input int hold_at);
		int   sent, declared, nbytes, pick, n;
		logic [IW-1:0] tag;
		logic held;
		sent = 0;
		held = 1'b0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 8) begin
				drive_beat(1'($urandom_range(1)), BW'($urandom_range(255)),
					1'($urandom_range(1)), LW'($urandom_range(2047)),
					IW'($urandom_range(65535)));
				sent++;
			end else begin
				pick = int'($urandom_range(99));
				if (pick < 60)
					declared = int'($urandom_range(12));
				else if (pick < 85)
					declared = int'($urandom_range(64, 13));
				else if (pick < 95)
					declared = int'($urandom_range(1024, 1000));
				else
					declared = int'($urandom_range(2047, 1025));
				pick = int'($urandom_range(99));
				if (pick < 80)
					nbytes = (declared > 24) ? int'($urandom_range(24, 1)) : declared;
				else if (pick < 90)
					nbytes = int'($urandom_range((declared > 24) ? 24 : declared));
				else
					nbytes = ((declared > 24) ? 24 : declared) + int'($urandom_range(3, 1));
				n = (nbytes == 0) ? 1 : nbytes;
				tag = IW'($urandom_range(65535));
				for (int i = 0; i < n; i++) begin
					while ($urandom_range(99) < pop_pct) begin
						pop_beat();
						sent++;
					end
					drive_beat(prq_pkg::ACT_PUSH, BW'($urandom_range(255)), (i == n - 1),
						LW'(declared), tag);
					sent++;
				end
			end
			if (!held && hold_at > 0 && sent >= hold_at) begin
				hold_req <= ~hold_req;
				held = 1'b1;
			end
		end
	endtask

	task automatic run_phase(input logic [GW-1:0] budget, input logic [LW-1:0] cap,
			input int n_items, input int pop_pct, input int gap, input int hold_at);
		apply_settings(budget, cap);
		gap_pct <= gap;
		run_traffic(n_items, pop_pct, hold_at);
	endtask

	initial begin
		logic [IW-1:0] tag;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = prq_pkg::ACT_PUSH;
		data_byte = '0;
		last = 1'b0;
		packet_length = '0;
		packet_id = '0;
		cfg_valid = 1'b0;
		cfg_index = prq_pkg::CFG_BUDGET;
		cfg_data = '0;
		gap_pct = 26;
		hold_req = 1'b0;
		beats_sent = 0;
		settings_used = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pop, zero-length, pop during push, oversize, short and long packets
		pop_beat();
		drive_beat(prq_pkg::ACT_PUSH, 8'h00, 1'b1, 11'd0, 16'hFFFF);
		drive_beat(prq_pkg::ACT_PUSH, 8'h00, 1'b0, 11'd3, 16'h0000);
		pop_beat();
		drive_beat(prq_pkg::ACT_PUSH, 8'hFF, 1'b0, 11'd3, 16'h0000);
		drive_beat(prq_pkg::ACT_PUSH, 8'hA5, 1'b1, 11'd3, 16'h0000);
		drive_beat(prq_pkg::ACT_PUSH, 8'h5A, 1'b1, 11'd2047, 16'h1234);
		drive_beat(prq_pkg::ACT_PUSH, 8'h11, 1'b0, 11'd1025, 16'h4321);
		drive_beat(prq_pkg::ACT_PUSH, 8'h22, 1'b1, 11'd1025, 16'h4321);
		drive_beat(prq_pkg::ACT_PUSH, 8'h33, 1'b0, 11'd5, 16'hAAAA);
		drive_beat(prq_pkg::ACT_PUSH, 8'h44, 1'b1, 11'd5, 16'hAAAA);
		drive_beat(prq_pkg::ACT_PUSH, 8'h55, 1'b0, 11'd1, 16'h5555);
		drive_beat(prq_pkg::ACT_PUSH, 8'h66, 1'b0, 11'd1, 16'h5555);
		drive_beat(prq_pkg::ACT_PUSH, 8'h77, 1'b1, 11'd1, 16'h5555);
		repeat (7) pop_beat();

		// one long packet declared at full size, partly read, then the read limit
		// cut below the read point
		tag = IW'($urandom_range(65535));
		for (int i = 0; i < 256; i++) begin
			if (i % 64 == 32)
				pop_beat();
			drive_beat(prq_pkg::ACT_PUSH, BW'($urandom_range(255)), (i == 255), 11'd1024, tag);
		end
		repeat (20) pop_beat();
		apply_settings(prq_pkg::BUDGET_RESET, 11'd10);
		pop_beat();

		run_phase(prq_pkg::BUDGET_RESET, prq_pkg::LIMIT_RESET, 300, 45, 26, 150);
		run_phase(14'd5000, 11'd7, 230, 20, 26, 0);
		run_phase(14'd0, 11'd0, 110, 40, 26, 0);
		run_phase(prq_pkg::BUDGET_RESET, prq_pkg::LIMIT_RESET, 190, 5, 26, 0);
		run_phase(prq_pkg::BUDGET_RESET, prq_pkg::LIMIT_RESET, 230, 45, 0, 0);
		run_phase(14'd1023, 11'd1, 120, 30, 26, 0);

		wait_drained();
		repeat (4) @(posedge clk);
		$display("Run covered %0d item beats under %0d register settings,", beats_sent,
			settings_used);
		$display("a long packet, admission rejects, truncation and a long output hold-off.");
		if (mismatch_count == 0 && answers_due == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: filelist.f
design/prq_pkg.sv
design/prq_ram.sv
design/prq_outreg.sv
design/packet_ring_queue.sv
bench/prq_answer_check.sv
bench/packet_ring_queue_tb.sv
